// ===== hdl/gre_pkg.sv =====
// ----------------------------------------------------------------------------
// Golomb-Rice encoder package
// Item types, register indexes and sizing constants that the encoder uses.
// ----------------------------------------------------------------------------
package gre_pkg;

  localparam int unsigned ChunkW    = 64;
  localparam int unsigned EscWidth  = 32;
  localparam int unsigned MaxLimit  = 1024;
  localparam int unsigned LimitW    = 11;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned KW        = 5;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ShAmtW    = 7;

  localparam logic [ValueW-1:0] SatHigh   = 32'h3FFF_FFFF;
  localparam logic [ValueW-1:0] SatLowMag = 32'h4000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSignedMapping = 2'd0,
    CfgEscapeLimit   = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [KW-1:0]     rice_k;
  } in_item_t;

  typedef struct packed {
    logic [ChunkW-1:0] code_bits;
    logic [CountW-1:0] bit_count;
    logic              last_chunk;
  } out_item_t;

endpackage

// ===== hdl/golomb_rice_encoder_escape.sv =====
// ----------------------------------------------------------------------------
// Golomb-Rice encoder with escape
// Maps each value, codes it as a Golomb-Rice word (escaped to a raw word above
// the limit or at it) and delivers the code as left-aligned 64-bit chunks.
// ----------------------------------------------------------------------------
//  channel  | signals                         | moves
//  ---------+---------------------------------+---------------------------------
//  input    | in_valid_i, in_ready_o, in_data_i   | value and Rice parameter
//  output   | out_valid_o, out_ready_i, out_data_o| code chunks of each item
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i | register writes, no wait
//
// An input item is taken in, the shared shifter aligns the remainder and
// escape bits, the unary ones go out a chunk at a time, the sequencer leaves
// the run of ones, then the remaining chunks go out. The chunk rate is set
// by the single output register, which is refilled in the cycle it is emptied.
// Reset clears the sequencer, the output valid and the registers to their
// defaults. A stalled output holds the sequencer in the states that emit a
// chunk.
// ----------------------------------------------------------------------------
module golomb_rice_encoder_escape (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  gre_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output gre_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [gre_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gre_pkg::LimitW-1:0]      cfg_data_i
);
  import gre_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StAlign,
    StOnes,
    StHead,
    StLast
  } state_e;

  state_e              state_q;
  logic                signed_q;
  logic [LimitW-1:0]   limit_q;
  logic [LimitW-1:0]   q_rem_q;
  logic [5:0]          t_q;
  logic [ChunkW-1:0]   y_q;
  logic [ChunkW-1:0]   low_q;
  logic [CountW-1:0]   low_cnt_q;
  logic                out_valid_q;
  out_item_t           out_q;

  // Mapping and coding set-up for the item at the input.
  logic [ValueW-1:0]   raw, mag, sat, n;
  logic [LimitW-1:0]   lim, m, mk, q_d;
  logic                esc;
  logic [5:0]          t_d;
  logic [ChunkW-1:0]   y_d;
  logic [KW-1:0]       k;

  always_comb begin
    raw = in_data_i.value;
    k   = in_data_i.rice_k;
    mag = (~raw) + ValueW'(1);
    sat = '0;
    if (!signed_q) begin
      n = raw;
    end else if (!raw[ValueW-1]) begin
      sat = (raw > SatHigh) ? SatHigh : raw;
      n   = sat << 1;
    end else begin
      sat = (mag > SatLowMag) ? SatLowMag : mag;
      n   = (sat << 1) + ValueW'(1);
    end

    if (limit_q == '0) begin
      lim = LimitW'(1);
    end else if (limit_q > LimitW'(MaxLimit)) begin
      lim = LimitW'(MaxLimit);
    end else begin
      lim = limit_q;
    end

    esc = (n >= ValueW'(lim));
    m   = esc ? lim : n[LimitW-1:0];
    q_d = m >> k;
    mk  = m & ~({LimitW{1'b1}} << k);
    t_d = 6'(k) + (esc ? 6'(EscWidth) : 6'd0);
    if (esc) begin
      y_d = (ChunkW'(mk) << EscWidth) | ChunkW'(n[EscWidth-1:0]);
    end else begin
      y_d = ChunkW'(mk);
    end
  end

  // The shared shifter: aligns the tail in one step and merges the unary
  // ones in front of it in another.
  logic [2*ChunkW-1:0] sh_in, sh_out;
  logic [ShAmtW-1:0]   sh_amt;
  logic                sh_fill;

  always_comb begin
    if (state_q == StAlign) begin
      sh_in   = {y_q, {ChunkW{1'b0}}};
      sh_amt  = ShAmtW'(t_q) + ShAmtW'(1);
      sh_fill = 1'b0;
    end else begin
      sh_in   = {y_q, {ChunkW{1'b0}}};
      sh_amt  = ShAmtW'(q_rem_q[5:0]);
      sh_fill = 1'b1;
    end
  end

  gre_shifter u_shifter (
    .data_i (sh_in),
    .amt_i  (sh_amt),
    .fill_i (sh_fill),
    .data_o (sh_out)
  );

  // Bits still to go once the remaining ones are fewer than a chunk.
  logic [CountW-1:0] tail_len;
  logic              out_free;
  logic              out_load;

  assign tail_len = CountW'(q_rem_q[5:0]) + CountW'(t_q) + CountW'(1);
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = out_free &&
                    (((state_q == StOnes) && (q_rem_q >= LimitW'(ChunkW))) ||
                     (state_q == StHead) || (state_q == StLast));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      signed_q    <= 1'b0;
      limit_q     <= LimitW'(MaxLimit);
      out_valid_q <= 1'b0;
      q_rem_q     <= '0;
      t_q         <= '0;
      y_q         <= '0;
      low_q       <= '0;
      low_cnt_q   <= '0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgSignedMapping) begin
          signed_q <= cfg_data_i[0];
        end else if (cfg_idx_i == CfgEscapeLimit) begin
          limit_q <= cfg_data_i;
        end
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            q_rem_q <= q_d;
            t_q     <= t_d;
            y_q     <= y_d;
            state_q <= StAlign;
          end
        end
        StAlign: begin
          y_q     <= sh_out[ChunkW-1:0];
          state_q <= StOnes;
        end
        StOnes: begin
          if (q_rem_q >= LimitW'(ChunkW)) begin
            if (out_free) begin
              out_q.code_bits      <= '1;
              out_q.bit_count      <= CountW'(ChunkW);
              out_q.last_chunk     <= 1'b0;
              q_rem_q              <= q_rem_q - LimitW'(ChunkW);
            end
          end else begin
            state_q <= StHead;
          end
        end
        StHead: begin
          if (out_free) begin
            out_q.code_bits  <= sh_out[2*ChunkW-1:ChunkW];
            low_q            <= sh_out[ChunkW-1:0];
            if (tail_len > CountW'(ChunkW)) begin
              out_q.bit_count  <= CountW'(ChunkW);
              out_q.last_chunk <= 1'b0;
              low_cnt_q        <= tail_len - CountW'(ChunkW);
              state_q          <= StLast;
            end else begin
              out_q.bit_count  <= tail_len;
              out_q.last_chunk <= 1'b1;
              state_q          <= StIdle;
            end
          end
        end
        StLast: begin
          if (out_free) begin
            out_q.code_bits  <= low_q;
            out_q.bit_count  <= low_cnt_q;
            out_q.last_chunk <= 1'b1;
            state_q          <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/gre_shifter.sv =====
// ----------------------------------------------------------------------------
// Shared funnel shifter
// Shifts a double-chunk word right by a variable amount, filling the vacated
// top bits with zeros or with ones.
// ----------------------------------------------------------------------------
module gre_shifter (
  input  logic [2*gre_pkg::ChunkW-1:0] data_i,
  input  logic [gre_pkg::ShAmtW-1:0]   amt_i,
  input  logic                         fill_i,
  output logic [2*gre_pkg::ChunkW-1:0] data_o
);
  import gre_pkg::*;

  // Filling with ones is a zero-filling shift of the inverted word.
  always_comb begin
    if (fill_i) begin
      data_o = ~((~data_i) >> amt_i);
    end else begin
      data_o = data_i >> amt_i;
    end
  end

endmodule

// ===== tb/sv/tb_golomb_rice_encoder_escape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Golomb-Rice encoder with escape: self-checking testbench
// Drives values and Rice parameters through the encoder under several register
// settings and checks every output chunk against the table or a bit-stream predictor.
// ----------------------------------------------------------------------------
module tb_golomb_rice_encoder_escape;
  import gre_pkg::*;

  localparam int unsigned HalfPeriodNs = 6;
  localparam int unsigned ResetCycles  = 8;
  localparam int unsigned LongHold     = 150;
  localparam int unsigned DrainCycles  = 40;
  localparam int unsigned PhaseItems   = 19;
  localparam int unsigned NumDirected  = 25;
  localparam longint unsigned TimeoutNs = 3_000_000;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef enum int {RxAlways, RxAlternate, RxMostly, RxSeldom} rx_mode_e;

  typedef struct packed {
    logic              sgn;
    logic [LimitW-1:0] lim;
    logic [ValueW-1:0] value;
    logic [KW-1:0]     k;
    logic              typed;
    logic [ChunkW-1:0] bits;
    logic [CountW-1:0] count;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [LimitW-1:0]  cfg_data_i;

  // Register copies for the predictor.
  logic              mapping_signed;
  logic [LimitW-1:0] limit_reg;

  out_item_t chunk_q[$];
  out_item_t chunk_want;
  int        mismatches;
  int        burst_left;
  int        hold_req;
  int        hold_done;

  // Directed items; the rows marked typed carry their expected single chunk.
  dir_row_t directed_tab [NumDirected] = '{
    '{1'b0, 11'd1024, 32'd0,          5'd0,  1'b1, 64'h0,                  7'd1},
    '{1'b0, 11'd1024, 32'd1,          5'd0,  1'b1, 64'h8000_0000_0000_0000, 7'd2},
    '{1'b0, 11'd1024, 32'd0,          5'd31, 1'b1, 64'h0,                  7'd32},
    '{1'b0, 11'd1024, 32'd5,          5'd2,  1'b1, 64'h9000_0000_0000_0000, 7'd4},
    '{1'b0, 11'd1024, 32'd63,         5'd0,  1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 7'd64},
    '{1'b0, 11'd1024, 32'd64,         5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1024, 32'd1023,       5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1024, 32'd1024,       5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1024, 32'hFFFF_FFFF,  5'd31, 1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1024, 32'hAAAA_AAAA,  5'd16, 1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1024, 32'h0000_03FF,  5'd31, 1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'd0,          5'd0,  1'b1, 64'h0,                  7'd1},
    '{1'b1, 11'd1024, 32'hFFFF_FFFF,  5'd1,  1'b1, 64'hA000_0000_0000_0000, 7'd3},
    '{1'b1, 11'd1024, 32'h3FFF_FFFF,  5'd31, 1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'h7FFF_FFFF,  5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'h8000_0000,  5'd5,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'hC000_0000,  5'd3,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'hC000_0001,  5'd10, 1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'h0000_01FF,  5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd1024, 32'h0000_0200,  5'd2,  1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd0,    32'd0,          5'd0,  1'b1, 64'h0,                  7'd1},
    '{1'b0, 11'd0,    32'd1,          5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd2047, 32'h0000_01FF,  5'd0,  1'b0, 64'h0,                  7'd0},
    '{1'b1, 11'd2047, 32'hFFFF_FE00,  5'd1,  1'b0, 64'h0,                  7'd0},
    '{1'b0, 11'd1,    32'hDEAD_BEEF,  5'd31, 1'b0, 64'h0,                  7'd0}
  };

  golomb_rice_encoder_escape u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(HalfPeriodNs) clk_i = ~clk_i;

  // Builds the code of one value as a bit stream and cuts it into chunks.
  function automatic void predict_chunks(input in_item_t item);
    logic [ValueW-1:0] n;
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] coded;
    int unsigned       lim;
    int unsigned       q;
    int                fill;
    logic              stream[$];
    out_item_t         cur;
    if (mapping_signed) begin
      if (!item.value[ValueW-1]) begin
        n = ((item.value > SatHigh) ? SatHigh : item.value) << 1;
      end else begin
        mag = ~item.value + 1'b1;
        if (mag > SatLowMag) mag = SatLowMag;
        n = (mag << 1) + 1'b1;
      end
    end else begin
      n = item.value;
    end
    lim = (limit_reg == 0) ? 1 : ((limit_reg > MaxLimit) ? MaxLimit : limit_reg);
    coded = (n < lim) ? n : ValueW'(lim);
    q = coded >> item.rice_k;
    repeat (q) stream.push_back(1'b1);
    stream.push_back(1'b0);
    for (int i = int'(item.rice_k) - 1; i >= 0; i--) stream.push_back(coded[i]);
    if (n >= lim) begin
      for (int i = EscWidth - 1; i >= 0; i--) stream.push_back(n[i]);
    end
    cur = '0;
    fill = 0;
    for (int i = 0; i < stream.size(); i++) begin
      cur.code_bits[ChunkW-1-fill] = stream[i];
      fill++;
      if (fill == ChunkW || i == stream.size() - 1) begin
        cur.bit_count  = CountW'(fill);
        cur.last_chunk = (i == stream.size() - 1);
        chunk_q.push_back(cur);
        cur = '0;
        fill = 0;
      end
    end
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.rice_k = KW'($urandom_range(0, 31));
    case ($urandom_range(0, 6))
      0, 1: it.value = $urandom_range(0, 1100);
      2: it.value = ~ValueW'($urandom_range(0, 600));
      3: it.value = $urandom();
      4: it.value = ($urandom_range(0, 1) ? 32'h3FFF_FFFE : 32'hBFFF_FFFF)
                    + $urandom_range(0, 2);
      5: it.value = ValueW'($urandom_range(0, 7)) << $urandom_range(0, 29);
      default: it.value = ValueW'(limit_reg) + $urandom_range(0, 4) - 2;
    endcase
    return it;
  endfunction

  // Offers one item, records its expected chunks when taken, then maybe idles.
  task automatic send_item(input in_item_t item, input logic typed,
                           input out_item_t typed_chunk);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    if (typed) chunk_q.push_back(typed_chunk);
    else predict_chunks(item);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // Stops offering items and waits for every expected chunk.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (chunk_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [LimitW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CfgSignedMapping) mapping_signed = data[0];
    else if (idx == CfgEscapeLimit) limit_reg = data;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic sgn, input logic [LimitW-1:0] lim);
    settle();
    cfg_write(CfgSignedMapping, {(LimitW-1)'($urandom()), sgn});
    cfg_write(CfgEscapeLimit, lim);
    cfg_write(CfgUnused, LimitW'($urandom()));
    cfg_we_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (chunk_q.size() == 0) begin
        $display("%0t: chunk with none expected: expected none, got %h", $time, out_data_o);
        mismatches++;
      end else begin
        chunk_want = chunk_q.pop_front();
        if (out_data_o.code_bits !== chunk_want.code_bits) begin
          $display("%0t: code_bits expected %h, got %h", $time, chunk_want.code_bits,
                   out_data_o.code_bits);
          mismatches++;
        end
        if (out_data_o.bit_count !== chunk_want.bit_count) begin
          $display("%0t: bit_count expected %0d, got %0d", $time, chunk_want.bit_count,
                   out_data_o.bit_count);
          mismatches++;
        end
        if (out_data_o.last_chunk !== chunk_want.last_chunk) begin
          $display("%0t: last_chunk expected %b, got %b", $time, chunk_want.last_chunk,
                   out_data_o.last_chunk);
          mismatches++;
        end
      end
    end
  end

  // The receiver changes its stall pattern now and then, and holds off for a
  // long stretch whenever the stimulus asks for one.
  initial begin : receiver
    int       mode_left;
    rx_mode_e mode;
    mode_left   = 0;
    mode        = RxAlways;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LongHold) @(negedge clk_i);
        hold_done++;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      case (mode)
        RxAlways:    out_ready_i <= 1'b1;
        RxAlternate: out_ready_i <= ~out_ready_i;
        RxMostly:    out_ready_i <= ($urandom_range(0, 3) != 0);
        default:     out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : stimulus
    out_item_t typed_chunk;
    logic      sgn;
    logic [LimitW-1:0] lim;
    mismatches     = 0;
    burst_left     = 0;
    hold_req       = 0;
    hold_done      = 0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgSignedMapping;
    cfg_data_i     = '0;
    mapping_signed = 1'b0;
    limit_reg      = LimitW'(MaxLimit);
    rst_ni         = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_tab[i]) begin
      if (directed_tab[i].sgn != mapping_signed || directed_tab[i].lim != limit_reg) begin
        set_config(directed_tab[i].sgn, directed_tab[i].lim);
      end
      typed_chunk = '{code_bits: directed_tab[i].bits, bit_count: directed_tab[i].count,
                      last_chunk: 1'b1};
      send_item('{value: directed_tab[i].value, rice_k: directed_tab[i].k},
                directed_tab[i].typed, typed_chunk);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sgn = 1'b0; lim = LimitW'(MaxLimit); end
        1: begin sgn = 1'b1; lim = LimitW'($urandom_range(1, 1023)); end
        2: begin sgn = 1'b0; lim = LimitW'($urandom_range(0, 2047)); end
        default: begin sgn = 1'b1; lim = LimitW'(MaxLimit); end
      endcase
      set_config(sgn, lim);
      // Stall the output while items keep coming, so the input backs up.
      if (phase == 1) hold_req++;
      repeat (PhaseItems) send_item(random_item(), 1'b0, '0);
    end

    settle();
    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("golomb_rice_encoder_escape test passed");
    end else begin
      $display("golomb_rice_encoder_escape test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("golomb_rice_encoder_escape test failed");
    $finish;
  end

endmodule
